[design/fire_seek_mode_sequencer_assert.svh]
// assertion macros shared by the sequencer modules
`ifndef FIRE_SEEK_MODE_SEQUENCER_ASSERT_SVH
`define FIRE_SEEK_MODE_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FSMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FSMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fsms_pkg.sv]
// types and constants of the fire-seek mode sequencer
package fsms_pkg;

    localparam int DIST_W  = 10;
    localparam int TICK_IN_W = 32;
    localparam int ANGLE_W = 8;
    localparam int PERIOD_W = 16;
    localparam int LIMIT_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
    localparam logic [ANGLE_W-1:0] HOLD_CENTER = 8'd90;
    localparam logic [ANGLE_W-1:0] HOLD_HOME   = 8'd0;

    typedef enum logic [0:0] {
        OP_SENSE   = 1'b0,
        OP_CONTROL = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        MODE_PATROL     = 3'd0,
        MODE_PAUSE      = 3'd1,
        MODE_TURN       = 3'd2,
        MODE_APPROACH   = 3'd3,
        MODE_FAN        = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        MOT_STOP     = 3'd0,
        MOT_FWD      = 3'd1,
        MOT_REV      = 3'd2,
        MOT_SPIN_L   = 3'd3,
        MOT_SPIN_R   = 3'd4,
        MOT_APPROACH = 3'd5
    } t_motion;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_LIMIT  = 3'd0,
        CFG_STOP_LIMIT    = 3'd1,
        CFG_PATROL_PERIOD = 3'd2,
        CFG_FAN_MAX       = 3'd3,
        CFG_PAUSE         = 3'd4,
        CFG_TURN          = 3'd5,
        CFG_RIGHT_SECTOR  = 3'd6,
        CFG_LEFT_SECTOR   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0]  detect_limit;
        logic [LIMIT_W-1:0]  stop_limit;
        logic [PERIOD_W-1:0] patrol_period;
        logic [PERIOD_W-1:0] fan_max;
        logic [PERIOD_W-1:0] pause_len;
        logic [PERIOD_W-1:0] turn_len;
        logic [ANGLE_W-1:0]  right_sector;
        logic [ANGLE_W-1:0]  left_sector;
    } t_cfg;

    typedef struct packed {
        t_op                  operation;
        logic [DIST_W-1:0]    distance_cm;
        logic [TICK_IN_W-1:0] now_tick;
        logic [1:0]           random_pick;
    } t_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] servo_angle;
        t_motion            motion;
        logic               fan_on;
        t_mode              mode;
        logic               fire_seen;
        logic               fire_near;
    } t_result;

endpackage

[design/fsms_in_if.sv]
// input item channel
interface fsms_in_if;
    import fsms_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [0:0]           operation;
    logic [DIST_W-1:0]    distance_cm;
    logic [TICK_IN_W-1:0] now_tick;
    logic [1:0]           random_pick;

    modport source (output valid, operation, distance_cm, now_tick, random_pick,
                    input ready);
    modport sink (input valid, operation, distance_cm, now_tick, random_pick,
                  output ready);
endinterface

[design/fsms_out_if.sv]
// result item channel
interface fsms_out_if;
    import fsms_pkg::*;

    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] servo_angle;
    logic [2:0]         motion;
    logic               fan_on;
    logic [2:0]         mode;
    logic               fire_seen;
    logic               fire_near;

    modport source (output valid, servo_angle, motion, fan_on, mode, fire_seen, fire_near,
                    input ready);
    modport sink (input valid, servo_angle, motion, fan_on, mode, fire_seen, fire_near,
                  output ready);
endinterface

[design/fsms_cfg_if.sv]
// configuration write channel
interface fsms_cfg_if;
    import fsms_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/fsms_core.sv]
// servo sweep, range latch and five-mode sequencer state
`include "fire_seek_mode_sequencer_assert.svh"

module fsms_core #(
    parameter int TICK_WIDTH  = 32,
    parameter int RANGE_WIDTH = 10,
    parameter int SWEEP_STEP  = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  fsms_pkg::t_item  i_item,
    input  fsms_pkg::t_cfg   i_cfg,
    output fsms_pkg::t_result o_result
);
    import fsms_pkg::*;

    localparam logic [RANGE_WIDTH-1:0] RANGE_MAX = '1;
    localparam int RANGE_RST_INT = (999 > (2**RANGE_WIDTH - 1)) ? (2**RANGE_WIDTH - 1) : 999;
    localparam logic [RANGE_WIDTH-1:0] RANGE_RST = RANGE_WIDTH'(RANGE_RST_INT);
    localparam logic [ANGLE_W-1:0] STEP = ANGLE_W'(SWEEP_STEP);

    t_mode                  r_mode, n_mode;
    t_motion                r_motion, n_motion;
    t_motion                r_patrol_motion, n_patrol_motion;
    logic [ANGLE_W-1:0]     r_angle, n_angle;
    logic [ANGLE_W-1:0]     r_hold, n_hold;
    logic                   r_sweep_up, n_sweep_up;
    logic                   r_scan, n_scan;
    logic                   r_fan, n_fan;
    logic [RANGE_WIDTH-1:0] r_range, n_range;
    logic [TICK_WIDTH-1:0]  r_patrol_dl, n_patrol_dl;
    logic [TICK_WIDTH-1:0]  r_pause_start, n_pause_start;
    logic [TICK_WIDTH-1:0]  r_turn_dl, n_turn_dl;
    logic [TICK_WIDTH-1:0]  r_fan_start, n_fan_start;

    logic [63:0]           now_wide;
    logic [TICK_WIDTH-1:0] now;
    logic                  is_ctrl;
    logic                  lost;
    logic                  far;
    logic                  patrol_due;
    logic                  turn_due;
    logic                  pause_done;
    logic                  fan_done;
    logic [TICK_WIDTH-1:0] patrol_diff, turn_diff, pause_el, fan_el;
    logic [ANGLE_W:0]      up_sum;

    assign now_wide = {32'd0, i_item.now_tick};
    assign now      = now_wide[TICK_WIDTH-1:0];
    assign is_ctrl  = (i_item.operation == OP_CONTROL);

    assign lost = 16'(r_range) > 16'(i_cfg.detect_limit);
    assign far  = 16'(r_range) > 16'(i_cfg.stop_limit);

    // wrap-safe timer tests
    assign patrol_diff = now - r_patrol_dl;
    assign turn_diff   = now - r_turn_dl;
    assign pause_el    = now - r_pause_start;
    assign fan_el      = now - r_fan_start;
    assign patrol_due  = !patrol_diff[TICK_WIDTH-1];
    assign turn_due    = !turn_diff[TICK_WIDTH-1];
    assign pause_done  = pause_el >= TICK_WIDTH'(i_cfg.pause_len);
    assign fan_done    = fan_el >= TICK_WIDTH'(i_cfg.fan_max);

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (is_ctrl) begin
            unique case (r_mode)
                MODE_PATROL: begin
                    if (!lost) n_mode = MODE_PAUSE;
                end
                MODE_PAUSE: begin
                    if (lost) begin
                        n_mode = MODE_PATROL;
                    end else if (pause_done) begin
                        if (r_angle < i_cfg.right_sector || r_angle > i_cfg.left_sector) begin
                            n_mode = MODE_TURN;
                        end else begin
                            n_mode = MODE_APPROACH;
                        end
                    end
                end
                MODE_TURN: begin
                    if (lost) n_mode = MODE_PATROL;
                    else if (turn_due) n_mode = MODE_APPROACH;
                end
                MODE_APPROACH: begin
                    if (lost) n_mode = MODE_PATROL;
                    else if (!far) n_mode = MODE_FAN;
                end
                MODE_FAN: begin
                    if (fan_done || lost) n_mode = MODE_PATROL;
                end
                default: n_mode = MODE_PATROL;
            endcase
        end
    end

    // control-step outputs and timers
    always_comb begin
        n_motion        = r_motion;
        n_patrol_motion = r_patrol_motion;
        n_hold          = r_hold;
        n_scan          = r_scan;
        n_fan           = r_fan;
        n_patrol_dl     = r_patrol_dl;
        n_pause_start   = r_pause_start;
        n_turn_dl       = r_turn_dl;
        n_fan_start     = r_fan_start;
        if (is_ctrl) begin
            unique case (r_mode)
                MODE_PATROL: begin
                    n_scan = 1'b1;
                    n_hold = r_angle;
                    n_fan  = 1'b0;
                    if (lost) begin
                        if (patrol_due) begin
                            n_patrol_motion = t_motion'(3'(i_item.random_pick) + 3'd1);
                            n_patrol_dl     = now + TICK_WIDTH'(i_cfg.patrol_period);
                        end
                        n_motion = n_patrol_motion;
                    end else begin
                        n_motion      = MOT_STOP;
                        n_scan        = 1'b0;
                        n_pause_start = now;
                    end
                end
                MODE_PAUSE: begin
                    if (!lost) begin
                        if (pause_done) begin
                            if (r_angle < i_cfg.right_sector) begin
                                n_motion  = MOT_SPIN_R;
                                n_turn_dl = now + TICK_WIDTH'(i_cfg.turn_len);
                            end else if (r_angle > i_cfg.left_sector) begin
                                n_motion  = MOT_SPIN_L;
                                n_turn_dl = now + TICK_WIDTH'(i_cfg.turn_len);
                            end
                        end else begin
                            n_motion = MOT_STOP;
                        end
                    end
                end
                MODE_TURN: begin
                    if (lost || turn_due) n_motion = MOT_STOP;
                end
                MODE_APPROACH: begin
                    n_scan = 1'b0;
                    n_hold = HOLD_CENTER;
                    if (lost) begin
                        n_motion = MOT_STOP;
                        n_fan    = 1'b0;
                        n_scan   = 1'b1;
                    end else if (far) begin
                        n_motion = MOT_APPROACH;
                    end else begin
                        n_motion    = MOT_STOP;
                        n_fan       = 1'b1;
                        n_fan_start = now;
                    end
                end
                MODE_FAN: begin
                    n_motion = MOT_STOP;
                    if (fan_done || lost) begin
                        n_fan  = 1'b0;
                        n_scan = 1'b1;
                        n_hold = HOLD_HOME;
                    end
                end
                default: n_motion = MOT_STOP;
            endcase
        end
    end

    // servo sweep and range latch on a sensor update
    assign up_sum = {1'b0, r_angle} + {1'b0, STEP};

    always_comb begin
        n_angle    = r_angle;
        n_sweep_up = r_sweep_up;
        n_range    = r_range;
        if (!is_ctrl) begin
            if (r_scan) begin
                if (r_sweep_up) begin
                    if (up_sum >= {1'b0, ANGLE_MAX}) begin
                        n_angle    = ANGLE_MAX;
                        n_sweep_up = 1'b0;
                    end else begin
                        n_angle = up_sum[ANGLE_W-1:0];
                    end
                end else begin
                    if (r_angle <= STEP) begin
                        n_angle    = '0;
                        n_sweep_up = 1'b1;
                    end else begin
                        n_angle = r_angle - STEP;
                    end
                end
            end else begin
                n_angle = r_hold;
            end
            if (16'(i_item.distance_cm) > 16'(RANGE_MAX)) n_range = RANGE_MAX;
            else n_range = RANGE_WIDTH'(i_item.distance_cm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_PATROL;
            r_motion        <= MOT_STOP;
            r_patrol_motion <= MOT_STOP;
            r_angle         <= '0;
            r_hold          <= HOLD_CENTER;
            r_sweep_up      <= 1'b1;
            r_scan          <= 1'b1;
            r_fan           <= 1'b0;
            r_range         <= RANGE_RST;
            r_patrol_dl     <= '0;
            r_pause_start   <= '0;
            r_turn_dl       <= '0;
            r_fan_start     <= '0;
        end else if (i_accept) begin
            r_mode          <= n_mode;
            r_motion        <= n_motion;
            r_patrol_motion <= n_patrol_motion;
            r_angle         <= n_angle;
            r_hold          <= n_hold;
            r_sweep_up      <= n_sweep_up;
            r_scan          <= n_scan;
            r_fan           <= n_fan;
            r_range         <= n_range;
            r_patrol_dl     <= n_patrol_dl;
            r_pause_start   <= n_pause_start;
            r_turn_dl       <= n_turn_dl;
            r_fan_start     <= n_fan_start;
        end
    end

    // result reflects the state after this item
    always_comb begin
        o_result.servo_angle = n_angle;
        o_result.motion      = n_motion;
        o_result.fan_on      = n_fan;
        o_result.mode        = n_mode;
        o_result.fire_seen   = 16'(n_range) <= 16'(i_cfg.detect_limit);
        o_result.fire_near   = 16'(n_range) <= 16'(i_cfg.stop_limit);
    end

    `FSMS_ASSERT_IMP(a_fan_iff_ext, i_clk, i_rst_n, 1'b1, r_fan == (r_mode == MODE_FAN), "fan state disagrees with mode")
    `FSMS_ASSERT_IMP(a_scan_off_busy, i_clk, i_rst_n, r_mode != MODE_PATROL, !r_scan, "servo scanning outside patrol")
    `FSMS_ASSERT_IMP(a_ext_stopped, i_clk, i_rst_n, r_mode == MODE_FAN, r_motion == MOT_STOP, "moving while extinguishing")

endmodule

[design/fire_seek_mode_sequencer.sv]
// fire-seek mode sequencer: top level with handshake, configuration and result register
// Takes one item per clock cycle unless stalled, sensor updates and control steps mixed in any order,
// and returns exactly one result per item, registered, in the cycle after acceptance. The
// whole state update of an item is combinational compares and adds on the state
// registers, so the following item sees it immediately; the only stall is a result
// still waiting in the output register while the receiver is not ready. Configuration
// writes are always accepted and take effect at once; write them only while idle.
`include "fire_seek_mode_sequencer_assert.svh"

module fire_seek_mode_sequencer #(
    parameter int TICK_WIDTH  = 32,
    parameter int RANGE_WIDTH = 10,
    parameter int SWEEP_STEP  = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsms_in_if.sink     i_in,
    fsms_cfg_if.sink    i_cfg,
    fsms_out_if.source  o_out
);
    import fsms_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    in_acc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign item.operation   = t_op'(i_in.operation);
    assign item.distance_cm = i_in.distance_cm;
    assign item.now_tick    = i_in.now_tick;
    assign item.random_pick = i_in.random_pick;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_limit  <= 10'd300;
            r_cfg.stop_limit    <= 10'd50;
            r_cfg.patrol_period <= 16'd3000;
            r_cfg.fan_max       <= 16'd5000;
            r_cfg.pause_len     <= 16'd300;
            r_cfg.turn_len      <= 16'd1308;
            r_cfg.right_sector  <= 8'd60;
            r_cfg.left_sector   <= 8'd120;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_DETECT_LIMIT:  r_cfg.detect_limit  <= i_cfg.data[LIMIT_W-1:0];
                CFG_STOP_LIMIT:    r_cfg.stop_limit    <= i_cfg.data[LIMIT_W-1:0];
                CFG_PATROL_PERIOD: r_cfg.patrol_period <= i_cfg.data[PERIOD_W-1:0];
                CFG_FAN_MAX:       r_cfg.fan_max       <= i_cfg.data[PERIOD_W-1:0];
                CFG_PAUSE:         r_cfg.pause_len     <= i_cfg.data[PERIOD_W-1:0];
                CFG_TURN:          r_cfg.turn_len      <= i_cfg.data[PERIOD_W-1:0];
                CFG_RIGHT_SECTOR:  r_cfg.right_sector  <= i_cfg.data[ANGLE_W-1:0];
                CFG_LEFT_SECTOR:   r_cfg.left_sector   <= i_cfg.data[ANGLE_W-1:0];
                default:           r_cfg.left_sector   <= r_cfg.left_sector;
            endcase
        end
    end

    fsms_core #(
        .TICK_WIDTH  (TICK_WIDTH),
        .RANGE_WIDTH (RANGE_WIDTH),
        .SWEEP_STEP  (SWEEP_STEP)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.servo_angle = r_out.servo_angle;
    assign o_out.motion      = r_out.motion;
    assign o_out.fan_on      = r_out.fan_on;
    assign o_out.mode        = r_out.mode;
    assign o_out.fire_seen   = r_out.fire_seen;
    assign o_out.fire_near   = r_out.fire_near;

    `FSMS_ASSERT_IMP(a_stall_blocks_in, i_clk, i_rst_n, r_out_valid && !o_out.ready, !i_in.ready, "item taken while result stalled")
    `FSMS_ASSERT_IMP(a_empty_takes_in, i_clk, i_rst_n, !r_out_valid, i_in.ready, "input blocked with empty result register")
    `FSMS_ASSERT_NXT(a_accept_gives_out, i_clk, i_rst_n, in_acc, r_out_valid, "accepted item produced no result")

endmodule

[tb/tb_fire_seek_mode_sequencer.sv]
// self-checking testbench of the fire-seek mode sequencer with its own behavioral predictor
module tb_fire_seek_mode_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import fsms_pkg::*;

    localparam int          SWEEP_STEP  = 10;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    fsms_in_if  in_ch();
    fsms_cfg_if cfg_ch();
    fsms_out_if out_ch();

    fire_seek_mode_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // shadow of the configuration and of the sequencer state
    t_cfg        cfg_shadow;
    t_mode       sq_mode;
    t_motion     sq_motion;
    t_motion     sq_patrol;
    logic [7:0]  sq_angle;
    logic [7:0]  sq_hold;
    logic [9:0]  sq_range;
    bit          sq_up;
    bit          sq_scan;
    bit          sq_fan;
    logic [31:0] patrol_due;
    logic [31:0] pause_t0;
    logic [31:0] turn_due;
    logic [31:0] fan_t0;

    t_result     pending_results[$];
    int unsigned error_count;
    int unsigned cycle_count;
    bit          src_burst;
    bit          no_gaps;
    bit          sink_hold;
    logic [31:0] tick_now;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_fire_seek_mode_sequencer: errors");
        $finish;
    end

    function automatic bit tick_reached(logic [31:0] now, logic [31:0] due);
        logic [31:0] diff;
        diff = now - due;
        return !diff[31];
    endfunction

    function automatic bit tick_elapsed(logic [31:0] now, logic [31:0] t0, logic [15:0] len);
        logic [31:0] diff;
        diff = now - t0;
        return diff >= {16'd0, len};
    endfunction

    function automatic void sequencer_reset();
        cfg_shadow.detect_limit  = 10'd300;
        cfg_shadow.stop_limit    = 10'd50;
        cfg_shadow.patrol_period = 16'd3000;
        cfg_shadow.fan_max       = 16'd5000;
        cfg_shadow.pause_len     = 16'd300;
        cfg_shadow.turn_len      = 16'd1308;
        cfg_shadow.right_sector  = 8'd60;
        cfg_shadow.left_sector   = 8'd120;
        sq_mode    = MODE_PATROL;
        sq_motion  = MOT_STOP;
        sq_patrol  = MOT_STOP;
        sq_angle   = 8'd0;
        sq_hold    = HOLD_CENTER;
        sq_range   = 10'd999;
        sq_up      = 1'b1;
        sq_scan    = 1'b1;
        sq_fan     = 1'b0;
        patrol_due = '0;
        pause_t0   = '0;
        turn_due   = '0;
        fan_t0     = '0;
    endfunction

    // advances the shadow state by one item and returns the outputs after it
    function automatic t_result advance_sequencer(t_item it);
        t_result r;
        bit      lost;
        int      a;
        logic [31:0] now;
        now = it.now_tick;
        if (it.operation == OP_SENSE) begin
            if (sq_scan) begin
                a = int'(sq_angle);
                if (sq_up) begin
                    a += SWEEP_STEP;
                    if (a >= int'(ANGLE_MAX)) begin
                        a = int'(ANGLE_MAX);
                        sq_up = 1'b0;
                    end
                end else begin
                    a -= SWEEP_STEP;
                    if (a <= 0) begin
                        a = 0;
                        sq_up = 1'b1;
                    end
                end
                sq_angle = a[7:0];
            end else begin
                sq_angle = sq_hold;
            end
            sq_range = it.distance_cm;
        end else begin
            lost = sq_range > cfg_shadow.detect_limit;
            unique case (sq_mode)
                MODE_PATROL: begin
                    sq_scan = 1'b1;
                    sq_hold = sq_angle;
                    sq_fan  = 1'b0;
                    if (lost) begin
                        if (tick_reached(now, patrol_due)) begin
                            sq_patrol  = t_motion'({1'b0, it.random_pick} + 3'd1);
                            patrol_due = now + {16'd0, cfg_shadow.patrol_period};
                        end
                        sq_motion = sq_patrol;
                    end else begin
                        sq_motion = MOT_STOP;
                        sq_scan   = 1'b0;
                        pause_t0  = now;
                        sq_mode   = MODE_PAUSE;
                    end
                end
                MODE_PAUSE: begin
                    if (lost) begin
                        sq_mode = MODE_PATROL;
                    end else if (tick_elapsed(now, pause_t0, cfg_shadow.pause_len)) begin
                        if (sq_angle < cfg_shadow.right_sector) begin
                            sq_motion = MOT_SPIN_R;
                            turn_due  = now + {16'd0, cfg_shadow.turn_len};
                            sq_mode   = MODE_TURN;
                        end else if (sq_angle > cfg_shadow.left_sector) begin
                            sq_motion = MOT_SPIN_L;
                            turn_due  = now + {16'd0, cfg_shadow.turn_len};
                            sq_mode   = MODE_TURN;
                        end else begin
                            sq_mode = MODE_APPROACH;
                        end
                    end else begin
                        sq_motion = MOT_STOP;
                    end
                end
                MODE_TURN: begin
                    if (lost) begin
                        sq_motion = MOT_STOP;
                        sq_mode   = MODE_PATROL;
                    end else if (tick_reached(now, turn_due)) begin
                        sq_motion = MOT_STOP;
                        sq_mode   = MODE_APPROACH;
                    end
                end
                MODE_APPROACH: begin
                    sq_scan = 1'b0;
                    sq_hold = HOLD_CENTER;
                    if (lost) begin
                        sq_motion = MOT_STOP;
                        sq_fan    = 1'b0;
                        sq_scan   = 1'b1;
                        sq_mode   = MODE_PATROL;
                    end else if (sq_range > cfg_shadow.stop_limit) begin
                        sq_motion = MOT_APPROACH;
                    end else begin
                        sq_motion = MOT_STOP;
                        sq_fan    = 1'b1;
                        fan_t0    = now;
                        sq_mode   = MODE_FAN;
                    end
                end
                MODE_FAN: begin
                    sq_motion = MOT_STOP;
                    if (tick_elapsed(now, fan_t0, cfg_shadow.fan_max) || lost) begin
                        sq_fan  = 1'b0;
                        sq_scan = 1'b1;
                        sq_hold = HOLD_HOME;
                        sq_mode = MODE_PATROL;
                    end
                end
                default: begin
                    sq_motion = MOT_STOP;
                    sq_mode   = MODE_PATROL;
                end
            endcase
        end
        r.servo_angle = sq_angle;
        r.motion      = sq_motion;
        r.fan_on      = sq_fan;
        r.mode        = sq_mode;
        r.fire_seen   = sq_range <= cfg_shadow.detect_limit;
        r.fire_near   = sq_range <= cfg_shadow.stop_limit;
        return r;
    endfunction

    function automatic t_item sense_item(logic [9:0] range_cm);
        t_item it;
        it.operation   = OP_SENSE;
        it.distance_cm = range_cm;
        it.now_tick    = $urandom;
        it.random_pick = 2'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic t_item control_item(logic [31:0] now, logic [1:0] pick);
        t_item it;
        it.operation   = OP_CONTROL;
        it.distance_cm = 10'($urandom_range(0, 1023));
        it.now_tick    = now;
        it.random_pick = pick;
        return it;
    endfunction

    // random item: the target flag keeps ranges near or far for a while so modes advance
    function automatic t_item gen_item(inout bit target, input int unsigned span);
        t_item       it;
        int unsigned r;
        if ($urandom_range(0, 24) == 0) target = !target;
        it.random_pick = 2'($urandom_range(0, 3));
        it.distance_cm = 10'($urandom_range(0, 1023));
        it.now_tick    = $urandom;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 0) begin
            it.operation = OP_SENSE;
            if (r < 10)
                it.distance_cm = 10'($urandom_range(0, 1023));
            else if (target && r < 55)
                it.distance_cm = 10'($urandom_range(0, cfg_shadow.stop_limit));
            else if (target)
                it.distance_cm = 10'($urandom_range(0, cfg_shadow.detect_limit));
            else if (cfg_shadow.detect_limit == 10'd1023)
                it.distance_cm = 10'($urandom_range(0, 1023));
            else
                it.distance_cm = 10'($urandom_range(cfg_shadow.detect_limit + 1, 1023));
        end else begin
            it.operation = OP_CONTROL;
            if (r < 70)
                tick_now += $urandom_range(0, span);
            else if (r < 85)
                tick_now += $urandom_range(0, 3);
            else if (r < 95)
                tick_now += $urandom_range(0, 4 * span);
            else
                tick_now += $urandom;
            it.now_tick = tick_now;
        end
        return it;
    endfunction

    task automatic send_item(t_item it);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        gap = (src_burst || no_gaps) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= it.operation;
        in_ch.distance_cm <= it.distance_cm;
        in_ch.now_tick    <= it.now_tick;
        in_ch.random_pick <= it.random_pick;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results.push_back(advance_sequencer(it));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        unique case (idx)
            CFG_DETECT_LIMIT:  cfg_shadow.detect_limit  = data[9:0];
            CFG_STOP_LIMIT:    cfg_shadow.stop_limit    = data[9:0];
            CFG_PATROL_PERIOD: cfg_shadow.patrol_period = data;
            CFG_FAN_MAX:       cfg_shadow.fan_max       = data;
            CFG_PAUSE:         cfg_shadow.pause_len     = data;
            CFG_TURN:          cfg_shadow.turn_len      = data;
            CFG_RIGHT_SECTOR:  cfg_shadow.right_sector  = data[7:0];
            CFG_LEFT_SECTOR:   cfg_shadow.left_sector   = data[7:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // noisy puts random bits above the width of the narrow registers
    task automatic load_config(t_cfg c, bit noisy);
        logic [15:0] n;
        n = noisy ? 16'($urandom) : 16'd0;
        write_reg(CFG_DETECT_LIMIT, {n[15:10], c.detect_limit});
        write_reg(CFG_STOP_LIMIT, {n[15:10], c.stop_limit});
        write_reg(CFG_PATROL_PERIOD, c.patrol_period);
        write_reg(CFG_FAN_MAX, c.fan_max);
        write_reg(CFG_PAUSE, c.pause_len);
        write_reg(CFG_TURN, c.turn_len);
        write_reg(CFG_RIGHT_SECTOR, {n[15:8], c.right_sector});
        write_reg(CFG_LEFT_SECTOR, {n[7:0], c.left_sector});
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_phase(int unsigned n, int unsigned span);
        bit target;
        target   = 1'($urandom_range(0, 1));
        tick_now = $urandom_range(0, 1) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
        for (int unsigned k = 0; k < n; k++)
            send_item(gen_item(target, span));
        drain();
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.servo_angle = out_ch.servo_angle;
        got.motion      = t_motion'(out_ch.motion);
        got.fan_on      = out_ch.fan_on;
        got.mode        = t_mode'(out_ch.mode);
        got.fire_seen   = out_ch.fire_seen;
        got.fire_near   = out_ch.fire_near;
        if (pending_results.size() == 0) begin
            if (error_count < 10)
                $display("unexpected result item: angle=%0d motion=%0d mode=%0d",
                         got.servo_angle, got.motion, got.mode);
            error_count++;
        end else begin
            want = pending_results.pop_front();
            if (got.servo_angle !== want.servo_angle || got.motion !== want.motion ||
                got.fan_on !== want.fan_on || got.mode !== want.mode ||
                got.fire_seen !== want.fire_seen || got.fire_near !== want.fire_near) begin
                if (error_count < 10) begin
                    $display("mismatch exp: angle=%0d motion=%0d fan=%0b mode=%0d seen=%0b near=%0b",
                             want.servo_angle, want.motion, want.fan_on, want.mode,
                             want.fire_seen, want.fire_near);
                    $display("         got: angle=%0d motion=%0d fan=%0b mode=%0d seen=%0b near=%0b",
                             got.servo_angle, got.motion, got.fan_on, got.mode,
                             got.fire_seen, got.fire_near);
                end
                error_count++;
            end
        end
    endtask

    initial begin : result_sink
        int unsigned gap_left;
        bit          burst;
        gap_left     = 0;
        burst        = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                check_result();
                if ($urandom_range(0, 39) == 0) burst = !burst;
                gap_left = burst ? 0 : $urandom_range(0, 17);
            end
            if (!i_rst_n || sink_hold) begin
                out_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // sweep from reset up to the top clamp and back down, with the field extremes
    task automatic test_sweep_clamp();
        logic [9:0] dists [8] = '{10'd0, 10'd1023, 10'd1, 10'd1022,
                                  10'd300, 10'd301, 10'd50, 10'd51};
        for (int k = 0; k < 18; k++)
            send_item(sense_item(k < 8 ? dists[k] : 10'($urandom_range(0, 1023))));
        send_item(sense_item(10'd1023));
        send_item(control_item(32'd0, 2'd0));
        send_item(control_item(32'hFFFF_FFFF, 2'd3));
    endtask

    // walks pause, loss in pause, turn, approach, extinguish and back to patrol
    task automatic test_mode_walk();
        send_item(sense_item(10'd200));
        send_item(control_item(32'd1000, 2'd1));
        send_item(sense_item(10'd1023));
        send_item(control_item(32'd1100, 2'd2));
        send_item(sense_item(10'd40));
        send_item(control_item(32'd2000, 2'd0));
        send_item(control_item(32'd2300, 2'd0));
        send_item(control_item(32'd3608, 2'd0));
        send_item(sense_item(10'd100));
        send_item(control_item(32'd3700, 2'd0));
        send_item(sense_item(10'd0));
        send_item(control_item(32'd4000, 2'd0));
        send_item(control_item(32'd9000, 2'd0));
        drain();
    endtask

    task automatic test_small_timers();
        t_cfg c;
        c.detect_limit  = 10'd300;
        c.stop_limit    = 10'd50;
        c.patrol_period = 16'($urandom_range(1, 40));
        c.fan_max       = 16'($urandom_range(1, 60));
        c.pause_len     = 16'($urandom_range(0, 30));
        c.turn_len      = 16'($urandom_range(0, 30));
        c.right_sector  = 8'd60;
        c.left_sector   = 8'd120;
        load_config(c, 1'b0);
        random_phase(300, 40);
    endtask

    task automatic test_low_extremes();
        t_cfg c;
        c = '0;
        load_config(c, 1'b0);
        random_phase(200, 4);
    endtask

    task automatic test_high_extremes();
        t_cfg c;
        c.detect_limit  = 10'd1023;
        c.stop_limit    = 10'd1023;
        c.patrol_period = 16'hFFFF;
        c.fan_max       = 16'hFFFF;
        c.pause_len     = 16'hFFFF;
        c.turn_len      = 16'hFFFF;
        c.right_sector  = ANGLE_MAX;
        c.left_sector   = ANGLE_MAX;
        load_config(c, 1'b0);
        random_phase(200, 30000);
    endtask

    task automatic test_random_config();
        t_cfg c;
        for (int k = 0; k < 3; k++) begin
            c.detect_limit  = 10'($urandom_range(0, 1023));
            c.stop_limit    = 10'($urandom_range(0, 1023));
            c.patrol_period = 16'($urandom_range(0, 200));
            c.fan_max       = 16'($urandom_range(0, 200));
            c.pause_len     = 16'($urandom_range(0, 200));
            c.turn_len      = 16'($urandom_range(0, 200));
            c.right_sector  = 8'($urandom_range(0, 180));
            c.left_sector   = 8'($urandom_range(0, 180));
            load_config(c, 1'b1);
            random_phase(150, 150);
        end
    endtask

    task automatic test_default_timing();
        t_cfg c;
        c.detect_limit  = 10'd300;
        c.stop_limit    = 10'd50;
        c.patrol_period = 16'd3000;
        c.fan_max       = 16'd5000;
        c.pause_len     = 16'd300;
        c.turn_len      = 16'd1308;
        c.right_sector  = 8'd60;
        c.left_sector   = 8'd120;
        load_config(c, 1'b0);
        random_phase(150, 2000);
    endtask

    // receiver holds off while the sender keeps offering items back to back
    task automatic test_backpressure();
        t_cfg c;
        bit   target;
        c.detect_limit  = 10'd300;
        c.stop_limit    = 10'd50;
        c.patrol_period = 16'd20;
        c.fan_max       = 16'd30;
        c.pause_len     = 16'd5;
        c.turn_len      = 16'd10;
        c.right_sector  = 8'd60;
        c.left_sector   = 8'd120;
        load_config(c, 1'b0);
        target  = 1'b1;
        no_gaps = 1'b1;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (120) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
            for (int k = 0; k < 40; k++)
                send_item(gen_item(target, 20));
        join
        no_gaps = 1'b0;
        drain();
    endtask

    initial begin
        error_count       = 0;
        src_burst         = 1'b0;
        no_gaps           = 1'b0;
        sink_hold         = 1'b0;
        tick_now          = '0;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_SENSE;
        in_ch.distance_cm = '0;
        in_ch.now_tick    = '0;
        in_ch.random_pick = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_DETECT_LIMIT;
        cfg_ch.data       = '0;
        sequencer_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_sweep_clamp();
        test_mode_walk();
        test_small_timers();
        test_low_extremes();
        test_high_extremes();
        test_random_config();
        test_default_timing();
        test_backpressure();

        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_fire_seek_mode_sequencer: clean");
        end else begin
            $display("tb_fire_seek_mode_sequencer: errors");
        end
        $finish;
    end

endmodule
